>>> rtl/sum_tree_weighted_sampler_macros.svh
// Assertion macros for the weighted sampler checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef SUM_TREE_WEIGHTED_SAMPLER_MACROS_SVH
`define SUM_TREE_WEIGHTED_SAMPLER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define STW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler check failed");

// Next-cycle implication, switched off while reset is high.
`define STW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler check failed");

// Next-cycle implication that also holds through reset.
`define STW_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sampler check failed");

`endif

>>> rtl/stw_pkg.sv
// Shared types and constants for the sum tree weighted sampler.
// Used by the controller, the datapath, the top level and the checker.
package stw_pkg;

  localparam int DEF_LEAVES = 512;

  localparam int W_POS  = 9;
  localparam int W_WGT  = 16;
  localparam int W_FRAC = 32;
  localparam int W_TOT  = 25;

  localparam int S_DATA_W = 64;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 1;

  localparam int WGT_LSB  = W_POS;
  localparam int FRAC_LSB = W_POS + W_WGT;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CHOOSE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_MUL,
    ST_DESC_INIT,
    ST_DESC,
    ST_CHECK,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_CLEAR,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_SWEEP,
    ACT_SET_LEAF,
    ACT_SET_UP,
    ACT_MUL,
    ACT_DESC_INIT,
    ACT_DESC_STEP,
    ACT_CHECK,
    ACT_READ_ISSUE,
    ACT_READ_TAKE
  } act_t;

  typedef struct packed {
    act_t act;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic sweep_last;
    logic set_top;
    logic desc_leaf;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/stw_ctrl.sv
// Controller state machine for the sum tree weighted sampler.
// Depends on stw_pkg; drives the datapath through dp_cmd_t only.
module stw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  stw_pkg::dp_status_t status,
  output stw_pkg::dp_cmd_t   cmd
);
  import stw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    cmd.act         = ACT_NONE;
    cmd.load_result = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.act = ACT_SWEEP;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.act = ACT_CAPTURE;
          case (status.in_op)
            OP_SET:    state_next = ST_SET_LEAF;
            OP_CHOOSE: state_next = ST_MUL;
            OP_CLEAR:  state_next = ST_CLEAR;
            OP_READ:   state_next = ST_RD_ISSUE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SET_LEAF: begin
        cmd.act    = ACT_SET_LEAF;
        state_next = ST_SET_UP;
      end
      ST_SET_UP: begin
        cmd.act = ACT_SET_UP;
        if (status.set_top) begin
          state_next = ST_FIN;
        end
      end
      ST_MUL: begin
        cmd.act    = ACT_MUL;
        state_next = ST_DESC_INIT;
      end
      ST_DESC_INIT: begin
        cmd.act    = ACT_DESC_INIT;
        state_next = ST_DESC;
      end
      ST_DESC: begin
        cmd.act = ACT_DESC_STEP;
        if (status.desc_leaf) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.act    = ACT_CHECK;
        state_next = ST_FIN;
      end
      ST_RD_ISSUE: begin
        cmd.act    = ACT_READ_ISSUE;
        state_next = ST_RD_TAKE;
      end
      ST_RD_TAKE: begin
        cmd.act    = ACT_READ_TAKE;
        state_next = ST_FIN;
      end
      ST_CLEAR: begin
        cmd.act = ACT_SWEEP;
        if (status.sweep_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here until the output register can take the word.
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

>>> rtl/stw_dpath.sv
// Datapath of the sum tree weighted sampler: node memory, descent and update
// arithmetic, and the output register. Depends on stw_pkg.
module stw_dpath #(
  parameter int LEAVES = stw_pkg::DEF_LEAVES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stw_pkg::dp_cmd_t              cmd,
  output stw_pkg::dp_status_t           status,
  input  logic [stw_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [stw_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [stw_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [stw_pkg::M_USER_W-1:0]  m_tuser
);
  import stw_pkg::*;

  localparam int LW    = $clog2(LEAVES);
  localparam int AW    = LW + 1;
  localparam int NW    = W_WGT + LW;
  localparam int DEPTH = 2 * LEAVES;
  localparam int PW    = W_FRAC + NW;

  // Node 1 is the root, leaf p is node LEAVES + p, node 0 is unused.
  logic [NW-1:0] mem [DEPTH];
  logic [NW-1:0] rd_q;

  logic [LW-1:0]    pos_q;
  logic [W_WGT-1:0] wgt_q;
  logic [W_FRAC-1:0] frac_q;
  logic [NW-1:0]    total_q;
  logic [AW-1:0]    idx_q;
  logic [NW-1:0]    acc_q;
  logic [PW-1:0]    prod_q;
  logic [AW-1:0]    sweep_q;

  logic [W_POS-1:0] stg_chosen;
  logic             stg_rej;
  logic [W_WGT-1:0] stg_leaf;

  logic [W_POS-1:0] res_chosen;
  logic             res_rej;
  logic [W_TOT-1:0] res_total;
  logic [W_WGT-1:0] res_leaf;
  logic             out_valid;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [NW-1:0] wr_data;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] leaf_node;
  logic [AW-1:0] parent;
  logic [NW-1:0] up_sum;
  logic          go_right;
  logic [NW-1:0] step_r;
  logic [AW-1:0] step_idx;
  logic [AW-1:0] child;
  logic          desc_leaf;

  assign leaf_node = {1'b1, pos_q};
  assign parent    = idx_q >> 1;
  assign up_sum    = acc_q + rd_q;
  assign go_right  = (acc_q >= rd_q);
  assign step_r    = go_right ? (acc_q - rd_q) : acc_q;
  assign step_idx  = idx_q + AW'(go_right);
  assign child     = {step_idx[AW-2:0], 1'b0};
  assign desc_leaf = idx_q[AW-1];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    case (cmd.act)
      ACT_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
      end
      ACT_SET_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = leaf_node;
        wr_data = NW'(wgt_q);
        rd_addr = leaf_node ^ AW'(1);
      end
      ACT_SET_UP: begin
        // Write the parent with the running sum and fetch its sibling.
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = up_sum;
        rd_addr = parent ^ AW'(1);
      end
      ACT_DESC_INIT: begin
        rd_addr = AW'(2);
      end
      ACT_DESC_STEP: begin
        rd_addr = desc_leaf ? step_idx : child;
      end
      ACT_READ_ISSUE: begin
        rd_addr = leaf_node;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_q   <= '0;
      total_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.act == ACT_SWEEP) begin
        sweep_q <= sweep_q + AW'(1);
        total_q <= '0;
      end
      if (cmd.act == ACT_SET_UP && parent == AW'(1)) begin
        total_q <= up_sum;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_CAPTURE: begin
        pos_q      <= LW'(s_tdata[W_POS-1:0]);
        wgt_q      <= s_tdata[WGT_LSB +: W_WGT];
        frac_q     <= s_tdata[FRAC_LSB +: W_FRAC];
        stg_chosen <= '0;
        stg_rej    <= 1'b0;
        stg_leaf   <= '0;
      end
      ACT_SET_LEAF: begin
        acc_q <= NW'(wgt_q);
        idx_q <= leaf_node;
      end
      ACT_SET_UP: begin
        acc_q <= up_sum;
        idx_q <= parent;
      end
      ACT_MUL: begin
        prod_q <= PW'(frac_q) * PW'(total_q);
      end
      ACT_DESC_INIT: begin
        acc_q <= prod_q[PW-1:W_FRAC];
        idx_q <= AW'(2);
      end
      ACT_DESC_STEP: begin
        acc_q <= step_r;
        idx_q <= desc_leaf ? step_idx : child;
      end
      ACT_CHECK: begin
        if (rd_q == '0) begin
          stg_rej <= 1'b1;
        end else begin
          stg_chosen <= W_POS'(idx_q[LW-1:0]);
        end
      end
      ACT_READ_TAKE: begin
        stg_leaf <= rd_q[W_WGT-1:0];
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
    if (cmd.load_result) begin
      res_chosen <= stg_chosen;
      res_rej    <= stg_rej;
      res_total  <= W_TOT'(total_q);
      res_leaf   <= stg_leaf;
    end
  end

  assign status.in_op      = op_t'(s_tuser);
  assign status.sweep_last = &sweep_q;
  assign status.set_top    = (parent == AW'(1));
  assign status.desc_leaf  = desc_leaf;
  assign status.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'({res_leaf, res_total, res_chosen});
  assign m_tuser  = M_USER_W'(res_rej);

endmodule

>>> rtl/sum_tree_weighted_sampler.sv
// Top level of the sum tree weighted sampler: controller plus datapath.
// Depends on stw_pkg, stw_ctrl and stw_dpath.
//
//   Channel  Signals                              Carries
//   s_       tvalid tready tdata[63:0] tuser[1:0] one operation word
//   m_       tvalid tready tdata[55:0] tuser[0:0] one result word per operation
//
// With L = log2(LEAVES), set and choose walk the tree one level at a time, reading
// or writing one node memory entry per level, so their run time grows with L; clear
// sweeps every node memory entry and read fetches a single leaf.
// After reset all node memory entries are zeroed by a sweep; no word is taken
// until that sweep ends. A new word is taken while a result waits downstream;
// the controller only stalls when the next result is ready and the last is untaken.
module sum_tree_weighted_sampler #(
  parameter int LEAVES = stw_pkg::DEF_LEAVES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // position [8:0], weight [24:9], random_fraction [56:25], zeros above
  input  logic [stw_pkg::S_DATA_W-1:0] s_tdata,
  // opcode [1:0]
  input  logic [stw_pkg::S_USER_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // chosen_position [8:0], total_weight [33:9], leaf_weight [49:34], zeros above
  output logic [stw_pkg::M_DATA_W-1:0] m_tdata,
  // rejected [0]
  output logic [stw_pkg::M_USER_W-1:0] m_tuser
);
  import stw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stw_dpath #(
    .LEAVES (LEAVES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/stw_checker.sv
// Port-level checks for the sum tree weighted sampler, bound to the top level.
// Depends on stw_pkg and sum_tree_weighted_sampler_macros.svh.
`include "sum_tree_weighted_sampler_macros.svh"

module stw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [stw_pkg::M_DATA_W-1:0] m_tdata,
  input logic [stw_pkg::M_USER_W-1:0] m_tuser
);
  import stw_pkg::*;

  // Reset empties the output register.
  `STW_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !m_tvalid)

  // One word is worked on at a time, so ready drops after each acceptance.
  `STW_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

  // A rejected choice never names a leaf.
  `STW_ASSERT_NOW(a_reject_no_leaf, m_tvalid && m_tuser[0], m_tdata[W_POS-1:0] == '0)

  // A stalled result word holds.
  `STW_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind sum_tree_weighted_sampler stw_checker u_stw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
// Testbench for sum_tree_weighted_sampler: drives set, choose, clear and read words
// and checks every result word against a sum tree predictor kept in the bench.
// Depends on stw_pkg and the sum_tree_weighted_sampler RTL.
module tb_top;
  import stw_pkg::*;

  localparam int LEAVES         = DEF_LEAVES;
  localparam int WATCHDOG_LIMIT = 8 * LEAVES + 4000;
  localparam int SETTLE_CYCLES  = 2 * LEAVES + 16;

  typedef struct packed {
    logic [8:0]  chosen;
    logic        rejected;
    logic [24:0] total;
    logic [15:0] leaf_w;
  } sample_word_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [S_USER_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  // Bench copy of the sum tree; node 1 is the root, leaf p is node LEAVES+p.
  logic [31:0]  tree_sum [0:2*LEAVES-1];
  sample_word_t expected_samples [$];
  int unsigned  mismatches   = 0;
  int unsigned  quiet_cycles = 0;
  bit           sender_gaps  = 1'b0;
  bit           sink_stalls  = 1'b0;

  sum_tree_weighted_sampler #(.LEAVES(LEAVES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one operation to the bench tree and returns the result word it should give.
  function automatic sample_word_t apply_operation(op_t op, logic [8:0] pos,
                                                   logic [15:0] w, logic [31:0] frac);
    sample_word_t res;
    logic [63:0]  prod;
    logic [31:0]  r;
    int unsigned  node;
    res = '0;
    case (op)
      OP_SET: begin
        node = LEAVES + pos;
        tree_sum[node] = {16'd0, w};
        node = node >> 1;
        while (node != 0) begin
          tree_sum[node] = tree_sum[2*node] + tree_sum[2*node+1];
          node = node >> 1;
        end
      end
      OP_CHOOSE: begin
        prod = {32'd0, frac} * {32'd0, tree_sum[1]};
        r    = prod[63:32];
        node = 2;
        // Go right when the scaled value reaches the left sum, taking that sum off.
        while (node < LEAVES) begin
          if (r >= tree_sum[node]) begin
            r    = r - tree_sum[node];
            node = node + 1;
          end
          node = node * 2;
        end
        if (r >= tree_sum[node]) node = node + 1;
        if (tree_sum[node] == 0) res.rejected = 1'b1;
        else res.chosen = 9'(node - LEAVES);
      end
      OP_CLEAR: begin
        foreach (tree_sum[k]) tree_sum[k] = '0;
      end
      default: begin
        res.leaf_w = tree_sum[LEAVES + pos][15:0];
      end
    endcase
    res.total = tree_sum[1][24:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    sample_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: data %h, user %h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        check_field("chosen_position", 32'(want.chosen), 32'(m_tdata[8:0]));
        check_field("rejected", 32'(want.rejected), 32'(m_tuser[0]));
        check_field("total_weight", 32'(want.total), 32'(m_tdata[33:9]));
        check_field("leaf_weight", 32'(want.leaf_w), 32'(m_tdata[49:34]));
      end
    end
  end

  // Result side stalls in bursts while enabled.
  initial begin
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        m_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Ends the run when nothing has moved on either side for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one operation word and records its prediction once taken.
  // tvalid is left high on return so that back-to-back words need no lowering.
  task automatic send_word(op_t op, logic [8:0] pos, logic [15:0] w, logic [31:0] frac);
    int unsigned gap;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, frac, w, pos};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    expected_samples.push_back(apply_operation(op, pos, w, frac));
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic test_empty_tree();
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'd0);
    send_word(OP_CHOOSE, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_READ, 9'd0, 16'hFFFF, $urandom);
    send_word(OP_READ, 9'd511, 16'd0, $urandom);
    send_word(OP_SET, 9'd7, 16'd0, $urandom);
    send_word(OP_CHOOSE, 9'd7, 16'd0, 32'h8000_0000);
  endtask

  task automatic test_edge_weights();
    send_word(OP_SET, 9'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_SET, 9'd511, 16'hFFFF, 32'd0);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'd0);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(OP_CHOOSE, 9'h1FF, 16'hFFFF, 32'h8000_0000);
    send_word(OP_CHOOSE, 9'h1FF, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(OP_READ, 9'd0, 16'd0, 32'd0);
    send_word(OP_READ, 9'd511, 16'd0, 32'd0);
    send_word(OP_READ, 9'd300, 16'd0, 32'd0);
    send_word(OP_SET, 9'd0, 16'd0, 32'd0);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'd0);
    send_word(OP_SET, 9'd511, 16'd1, 32'd0);
    send_word(OP_SET, 9'd256, 16'hFFFF, 32'd0);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'd0);
    send_word(OP_CLEAR, 9'h1FF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_CHOOSE, 9'd0, 16'd0, 32'h1234_5678);
    send_word(OP_READ, 9'd256, 16'd0, 32'd0);
  endtask

  // Every leaf at full weight gives the largest total the tree can hold, which still fits the result's total field.
  task automatic test_full_tree();
    for (int p = 0; p < LEAVES; p++)
      send_word(OP_SET, 9'(p), 16'hFFFF, $urandom);
    send_word(OP_CHOOSE, 9'($urandom), 16'($urandom), 32'd0);
    send_word(OP_CHOOSE, 9'($urandom), 16'($urandom), 32'hFFFF_FFFF);
    for (int n = 0; n < 6; n++)
      send_word(OP_CHOOSE, 9'($urandom), 16'($urandom), $urandom);
    send_word(OP_READ, 9'd511, 16'($urandom), $urandom);
    send_word(OP_READ, 9'd0, 16'($urandom), $urandom);
    wait_for_results();
    send_word(OP_CLEAR, 9'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(int unsigned count);
    op_t         op;
    int unsigned pick;
    logic [8:0]  pos;
    logic [15:0] w;
    logic [31:0] frac;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_SET;
      else if (pick < 75) op = OP_CHOOSE;
      else if (pick < 98) op = OP_READ;
      else op = OP_CLEAR;
      // A small group of hot leaves keeps reads landing on written weights.
      pos = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 7)) : 9'($urandom);
      case ($urandom_range(0, 5))
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        2:       w = 16'($urandom_range(1, 16));
        default: w = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       frac = 32'd0;
        1:       frac = 32'hFFFF_FFFF;
        default: frac = $urandom;
      endcase
      send_word(op, pos, w, frac);
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_empty_tree();
    test_edge_weights();
    wait_for_results();
    test_full_tree();
    test_random_traffic(1000);
    wait_for_results();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(160);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
